@@ sv/bpl_pkg.sv @@
// Shared types and constants for the bounded positional list.
// Used by bpl_ctrl, bpl_dp and bounded_positional_list_top; no dependencies.
package bpl_pkg;

  localparam int ACT_W  = 3;
  localparam int POS_W  = 5;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;

  // Request action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_POS   = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_POS   = 3'd5,
    ACT_DUMP      = 3'd6
  } action_t;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Kind of work an incoming request turns into
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INSERT,
    KIND_DELETE,
    KIND_DUMP
  } kind_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic peek;
    logic ins_a;
    logic ins_b;
    logic del_b;
    logic dump;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    kind_t kind;
    logic  walk_done;
  } stat_t;

endpackage

@@ sv/bounded_positional_list_top.sv @@
// Bounded positional list: a circular linked list in a CAPACITY-entry store.
// Depends on bpl_pkg, bpl_ctrl and bpl_dp.
// An error result comes in the cycle after the request; an insert or delete hops k links
// (k up to CAPACITY-1), one link per cycle; a dump of N streams N results, one per cycle.
// A new request is taken only once busy has fallen after the last one.
// Results never stall. Synchronous reset empties the list; the stores are not cleared.
module bounded_positional_list_top #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [bpl_pkg::ACT_W-1:0]         action,
  input  logic [bpl_pkg::POS_W-1:0]         position,
  input  logic signed [bpl_pkg::DATA_W-1:0] value,
  output logic                              strobe,
  output logic [bpl_pkg::ST_W-1:0]          status,
  output logic signed [bpl_pkg::DATA_W-1:0] data_out,
  output logic                              last
);

  bpl_pkg::cmd_t  cmd;
  bpl_pkg::stat_t stat;

  // Sequence each request
  bpl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the list and produce results
  bpl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .action   (action),
    .position (position),
    .value    (value),
    .cmd      (cmd),
    .stat     (stat),
    .strobe   (strobe),
    .status   (status),
    .data_out (data_out),
    .last     (last)
  );

endmodule

@@ sv/bpl_ctrl.sv @@
// Controller state machine for the bounded positional list.
// Depends on bpl_pkg for the command and status structs.
module bpl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bpl_pkg::stat_t stat,
  output bpl_pkg::cmd_t  cmd,
  output logic           busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_INS_A,
    S_INS_B,
    S_DEL_A,
    S_DEL_B,
    S_DUMP
  } state_t;

  state_t state;
  state_t state_next;
  logic   ins_mode;
  logic   ins_mode_next;
  logic   accept;

  assign accept = start && !busy;

  // Decode commands and next state
  always_comb begin
    cmd           = '0;
    state_next    = state;
    ins_mode_next = ins_mode;
    unique case (state)
      S_IDLE: begin
        cmd.accept = accept;
        if (accept) begin
          case (stat.kind)
            bpl_pkg::KIND_INSERT: begin
              state_next    = S_WALK;
              ins_mode_next = 1'b1;
            end
            bpl_pkg::KIND_DELETE: begin
              state_next    = S_WALK;
              ins_mode_next = 1'b0;
            end
            bpl_pkg::KIND_DUMP: state_next = S_DUMP;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_next = ins_mode ? S_INS_A : S_DEL_A;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_INS_A: begin
        cmd.ins_a  = 1'b1;
        state_next = S_INS_B;
      end
      S_INS_B: begin
        cmd.ins_b  = 1'b1;
        state_next = S_IDLE;
      end
      S_DEL_A: begin
        cmd.peek   = 1'b1;
        state_next = S_DEL_B;
      end
      S_DEL_B: begin
        cmd.del_b  = 1'b1;
        state_next = S_IDLE;
      end
      S_DUMP: begin
        cmd.dump = 1'b1;
        if (stat.walk_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and registered busy
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ins_mode <= 1'b0;
      busy     <= 1'b0;
    end else begin
      state    <= state_next;
      ins_mode <= ins_mode_next;
      busy     <= (state_next != S_IDLE);
    end
  end

  // Checks
  a_ins_order: assert property (@(posedge clk) disable iff (rst)
    state == S_INS_B |-> $past(state) == S_INS_A)
    else $error("insert link fix without node write");

  a_del_order: assert property (@(posedge clk) disable iff (rst)
    state == S_DEL_B |-> $past(state) == S_DEL_A)
    else $error("delete unlink without victim fetch");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.peek, cmd.ins_a, cmd.ins_b, cmd.del_b, cmd.dump}))
    else $error("conflicting datapath commands");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept && stat.kind != bpl_pkg::KIND_NONE |=> busy)
    else $error("busy not raised after accepted request");

endmodule

@@ sv/bpl_dp.sv @@
// Datapath for the bounded positional list: element and link memories,
// free map, front pointer, count, link walker and result registers.
// Depends on bpl_pkg for field widths, codes and the command/status structs.
module bpl_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [bpl_pkg::ACT_W-1:0]         action,
  input  logic [bpl_pkg::POS_W-1:0]         position,
  input  logic signed [bpl_pkg::DATA_W-1:0] value,
  input  bpl_pkg::cmd_t                     cmd,
  output bpl_pkg::stat_t                    stat,
  output logic                              strobe,
  output logic [bpl_pkg::ST_W-1:0]          status,
  output logic signed [bpl_pkg::DATA_W-1:0] data_out,
  output logic                              last
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > bpl_pkg::POS_W) ? CW : bpl_pkg::POS_W;

  // Storage
  logic [bpl_pkg::DATA_W-1:0] elem_mem [CAPACITY];
  logic [IW-1:0]              link_mem [CAPACITY];
  logic [CAPACITY-1:0]        free_map;
  logic [IW-1:0]              front;
  logic [CW-1:0]              count;

  // Walker and operation registers
  logic [IW-1:0]              cur;
  logic [IW-1:0]              victim;
  logic [CW-1:0]              remaining;
  logic [IW-1:0]              link_q;
  logic [bpl_pkg::DATA_W-1:0] elem_q;
  logic [bpl_pkg::DATA_W-1:0] word_q;
  logic [IW-1:0]              node_q;
  logic                       empty_q;
  logic                       pos0_q;
  logic                       single_q;

  // Result registers
  bpl_pkg::status_t           res_status;
  logic [bpl_pkg::DATA_W-1:0] res_data;
  logic                       res_last;

  // Request decode
  logic [CMPW-1:0]            cnt_w;
  logic [CMPW-1:0]            ep;
  logic [CMPW-1:0]            steps_w;
  logic                       err;
  bpl_pkg::status_t           err_status;
  bpl_pkg::kind_t             kind;
  logic [IW-1:0]              free_idx;
  logic [IW-1:0]              raddr;
  logic                       lwe;
  logic [IW-1:0]              lwaddr;
  logic [IW-1:0]              lwdata;

  assign cnt_w = CMPW'(count);

  // Check the request against count and capacity
  always_comb begin
    ep         = '0;
    err        = 1'b0;
    err_status = bpl_pkg::ST_OK;
    kind       = bpl_pkg::KIND_NONE;
    unique case (action)
      bpl_pkg::ACT_INS_FRONT, bpl_pkg::ACT_INS_BACK, bpl_pkg::ACT_INS_POS: begin
        if (action == bpl_pkg::ACT_INS_BACK) begin
          ep = cnt_w;
        end else if (action == bpl_pkg::ACT_INS_POS) begin
          ep = CMPW'(position);
        end
        if (ep > cnt_w) begin
          err        = 1'b1;
          err_status = bpl_pkg::ST_BADPOS;
        end else if (cnt_w == CMPW'(CAPACITY)) begin
          err        = 1'b1;
          err_status = bpl_pkg::ST_FULL;
        end else begin
          kind = bpl_pkg::KIND_INSERT;
        end
      end
      bpl_pkg::ACT_DEL_FRONT, bpl_pkg::ACT_DEL_BACK, bpl_pkg::ACT_DEL_POS: begin
        if (action == bpl_pkg::ACT_DEL_BACK) begin
          ep = cnt_w - CMPW'(1);
        end else if (action == bpl_pkg::ACT_DEL_POS) begin
          ep = CMPW'(position);
        end
        if (count == '0) begin
          err        = 1'b1;
          err_status = bpl_pkg::ST_EMPTY;
        end else if (ep >= cnt_w) begin
          err        = 1'b1;
          err_status = bpl_pkg::ST_BADPOS;
        end else begin
          kind = bpl_pkg::KIND_DELETE;
        end
      end
      bpl_pkg::ACT_DUMP: begin
        if (count == '0) begin
          err        = 1'b1;
          err_status = bpl_pkg::ST_EMPTY;
        end else begin
          kind = bpl_pkg::KIND_DUMP;
        end
      end
      default: kind = bpl_pkg::KIND_NONE;
    endcase
  end

  // Hops to the predecessor: the back for position zero or a dump, else position minus one
  always_comb begin
    if (count == '0) begin
      steps_w = '0;
    end else if (kind == bpl_pkg::KIND_DUMP || ep == '0) begin
      steps_w = cnt_w - CMPW'(1);
    end else begin
      steps_w = ep - CMPW'(1);
    end
  end

  // Find the lowest free entry
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map[i]) free_idx = IW'(i);
    end
  end

  assign stat.kind      = kind;
  assign stat.walk_done = (remaining == '0);

  // Read address: load the front, follow a link, or hold the cursor
  always_comb begin
    if (cmd.accept) begin
      raddr = front;
    end else if (cmd.step || cmd.peek) begin
      raddr = link_q;
    end else begin
      raddr = cur;
    end
  end

  // Link write port
  always_comb begin
    lwe    = 1'b0;
    lwaddr = cur;
    lwdata = link_q;
    if (cmd.ins_a) begin
      lwe    = 1'b1;
      lwaddr = node_q;
      lwdata = empty_q ? node_q : link_q;
    end else if (cmd.ins_b) begin
      lwe    = !empty_q;
      lwdata = node_q;
    end else if (cmd.del_b) begin
      lwe    = 1'b1;
    end
  end

  // Memories with registered reads
  always_ff @(posedge clk) begin
    if (lwe) link_mem[lwaddr] <= lwdata;
    if (cmd.ins_a) elem_mem[node_q] <= word_q;
    link_q <= link_mem[raddr];
    elem_q <= elem_mem[raddr];
  end

  // Latch the request and advance the walker
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (cmd.accept) begin
      remaining <= CW'(steps_w);
    end else if (cmd.step) begin
      remaining <= remaining - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur      <= front;
      word_q   <= value;
      node_q   <= free_idx;
      empty_q  <= (count == '0);
      pos0_q   <= (ep == '0);
      single_q <= (count == CW'(1));
    end else if (cmd.step) begin
      cur <= link_q;
    end
    if (cmd.peek) victim <= link_q;
  end

  // Update front, count and free map
  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      free_map <= '1;
    end else begin
      if (cmd.ins_a && (pos0_q || empty_q)) front <= node_q;
      if (cmd.ins_b) begin
        count            <= count + CW'(1);
        free_map[node_q] <= 1'b0;
      end
      if (cmd.del_b) begin
        count            <= count - CW'(1);
        free_map[victim] <= 1'b1;
        if (single_q) begin
          front <= '0;
        end else if (pos0_q) begin
          front <= link_q;
        end
      end
    end
  end

  // Drive one result per cycle when requested
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.accept && err) || cmd.ins_b || cmd.del_b || cmd.dump;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && err) begin
      res_status <= err_status;
      res_data   <= '0;
      res_last   <= 1'b1;
    end else if (cmd.ins_b) begin
      res_status <= bpl_pkg::ST_OK;
      res_data   <= '0;
      res_last   <= 1'b1;
    end else if (cmd.del_b) begin
      res_status <= bpl_pkg::ST_OK;
      res_data   <= elem_q;
      res_last   <= 1'b1;
    end else if (cmd.dump) begin
      res_status <= bpl_pkg::ST_OK;
      res_data   <= elem_q;
      res_last   <= (remaining == '0);
    end
  end

  assign status   = res_status;
  assign data_out = res_data;
  assign last     = res_last;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= CAPACITY)
    else $error("element count beyond capacity");

  a_free_count: assert property (@(posedge clk) disable iff (rst)
    $countones(free_map) == CAPACITY - int'(count))
    else $error("free map disagrees with element count");

  a_dump_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("result burst broken before last");

endmodule
